// ----- hdl/rqs_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rqs_pkg: shared types and constants of the row sorter
// Store geometry, operation codes and controller/datapath command structs.
// ----------------------------------------------------------------------------
package rqs_pkg;

  localparam int STORE_WORDS = 4096;
  localparam int MAX_COLUMNS = 16;
  localparam int AW          = $clog2(STORE_WORDS);
  localparam int CW          = $clog2(MAX_COLUMNS);
  localparam int CCW         = 5;
  localparam int KCW         = 4;
  localparam int RW          = 13;
  localparam int STACK_DEPTH = 16;
  localparam int SPW         = $clog2(STACK_DEPTH + 1);

  localparam logic [1:0] OP_WRITE  = 2'd0;
  localparam logic [1:0] OP_SORT   = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [1:0] REG_COLUMN_COUNT = 2'd0;
  localparam logic [1:0] REG_KEY_COLUMN   = 2'd1;

  // memory port source select
  localparam logic [2:0] MA_HOST  = 3'd0;
  localparam logic [2:0] MA_KEYI  = 3'd1;
  localparam logic [2:0] MA_KEYJ  = 3'd2;
  localparam logic [2:0] MA_PIVOT = 3'd3;
  localparam logic [2:0] MA_ROWI  = 3'd4;
  localparam logic [2:0] MA_ROWJ  = 3'd5;

  typedef struct packed {
    logic [2:0] mem_addr_sel;
    logic       mem_we;
    logic       mem_wdata_host;  // write host value, else buffer word
    logic       wr_to_j;         // buffer write goes to row j side
    logic       load_range;      // i <= 0, j <= n-1, set pivot row address
    logic       load_pivot;
    logic       inc_i;
    logic       dec_j;
    logic       buf_i_we;
    logic       buf_j_we;
    logic       col_clr;
    logic       col_inc;
    logic       finish_part;
    logic       pop;
    logic       start_sort;
  } rqs_cmd_t;

  typedef struct packed {
    logic key_lt;       // mem data < pivot
    logic key_gt;
    logic i_le_j;
    logic n_gt1;
    logic stack_empty;
    logic col_last;
  } rqs_sts_t;

endpackage
`default_nettype wire

// ----- hdl/rqs_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rqs_datapath: word store, row buffers, pointers and range stack
// Executes commands from the controller one memory access per cycle.
// ----------------------------------------------------------------------------
module rqs_datapath import rqs_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  rqs_cmd_t                cmd,
  output rqs_sts_t                sts,
  input  wire logic [AW-1:0]      host_addr,
  input  wire logic signed [31:0] host_data,
  input  wire logic [CCW-1:0]     column_count,
  input  wire logic [KCW-1:0]     key_column,
  input  wire logic [RW-1:0]      rows,
  output logic signed [31:0]      rd_word
);

  logic signed [31:0] store [STORE_WORDS];
  logic signed [31:0] buf_i [MAX_COLUMNS];
  logic signed [31:0] buf_j [MAX_COLUMNS];
  logic [RW-1:0]      stk_start [STACK_DEPTH];
  logic [RW-1:0]      stk_count [STACK_DEPTH];
  logic [SPW-1:0]     sp;
  logic signed [31:0] mem_q;
  logic signed [31:0] pivot;
  logic [RW-1:0]      base, n;
  logic signed [RW:0] i, j;
  logic [CW-1:0]      col;
  logic [AW-1:0]      row_i_addr, row_j_addr;   // word address of row start
  logic [AW-1:0]      addr;
  logic signed [31:0] wdata;
  logic [RW:0]        lcount, rstart, rcount;
  logic [CCW-1:0]     col_ext;

  // row start addresses, stepped by column_count as i and j move
  logic [AW-1:0] base_addr;
  logic [AW:0]   pivot_addr_w;

  assign col_ext = {{(CCW-CW){1'b0}}, col};

  always_comb begin
    case (cmd.mem_addr_sel)
      MA_HOST:  addr = host_addr;
      MA_KEYI:  addr = row_i_addr + AW'(key_column);
      MA_KEYJ:  addr = row_j_addr + AW'(key_column);
      MA_PIVOT: addr = pivot_addr_w[AW-1:0];
      MA_ROWI:  addr = row_i_addr + AW'(col_ext);
      MA_ROWJ:  addr = row_j_addr + AW'(col_ext);
      default:  addr = host_addr;
    endcase
    if (cmd.mem_wdata_host) wdata = host_data;
    else if (cmd.wr_to_j)   wdata = buf_i[col];
    else                    wdata = buf_j[col];
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_we) store[addr] <= wdata;
    mem_q <= store[addr];
  end

  assign sts.key_lt      = mem_q < pivot;
  assign sts.key_gt      = mem_q > pivot;
  assign sts.i_le_j      = i <= j;
  assign sts.n_gt1       = n > RW'(1);
  assign sts.stack_empty = sp == '0;
  assign sts.col_last    = col_ext == column_count - CCW'(1);
  assign rd_word         = mem_q;

  assign lcount = (RW+1)'(j + 1);
  assign rstart = (RW+1)'(base) + (RW+1)'(i);
  assign rcount = (RW+1)'(n) - (RW+1)'(i);

  // pivot key address: base_addr + (n/2)*cc + key_column, set when a range is loaded
  logic [AW:0] mid_acc;
  assign pivot_addr_w = mid_acc + (AW+1)'(key_column);

  always_ff @(posedge clk) begin
    if (cmd.buf_i_we) buf_i[col] <= mem_q;
    if (cmd.buf_j_we) buf_j[col] <= mem_q;
  end

  // the partition walk holds i and j as row indexes and their row addresses
  always_ff @(posedge clk) begin
    if (rst) begin
      sp <= '0;
      col <= '0;
      pivot <= '0;
    end else begin
      if (cmd.col_clr) col <= '0;
      else if (cmd.col_inc) col <= col + CW'(1);
      if (cmd.load_pivot) pivot <= mem_q;
      if (cmd.start_sort) begin
        sp   <= '0;
        base <= '0;
        base_addr <= '0;
        n    <= rows;
      end
      if (cmd.load_range) begin
        i <= '0;
        j <= (RW+1)'(n) - (RW+1)'(1);
        row_i_addr <= base_addr;
        row_j_addr <= AW'(base_addr + AW'((n - RW'(1)) * column_count));
        mid_acc <= (AW+1)'(base_addr) + (AW+1)'((n >> 1) * column_count);
      end
      if (cmd.inc_i) begin
        i <= i + (RW+1)'(1);
        row_i_addr <= row_i_addr + AW'(column_count);
      end
      if (cmd.dec_j) begin
        j <= j - (RW+1)'(1);
        row_j_addr <= row_j_addr - AW'(column_count);
      end
      if (cmd.finish_part) begin
        if (lcount < rcount) begin
          if (rcount > (RW+1)'(1)) begin
            stk_start[sp[SPW-2:0]] <= RW'(rstart);
            stk_count[sp[SPW-2:0]] <= RW'(rcount);
            sp <= sp + SPW'(1);
          end
          n <= RW'(lcount);
        end else begin
          if (lcount > (RW+1)'(1)) begin
            stk_start[sp[SPW-2:0]] <= base;
            stk_count[sp[SPW-2:0]] <= RW'(lcount);
            sp <= sp + SPW'(1);
          end
          base <= RW'(rstart);
          base_addr <= row_i_addr;
          n <= RW'(rcount);
        end
      end
      if (cmd.pop) begin
        sp <= sp - SPW'(1);
        base <= stk_start[sp[SPW-2:0] - (SPW-1)'(1)];
        n    <= stk_count[sp[SPW-2:0] - (SPW-1)'(1)];
        base_addr <= AW'(stk_start[sp[SPW-2:0] - (SPW-1)'(1)] * column_count);
      end
    end
  end

endmodule
`default_nettype wire

// ----- hdl/rqs_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rqs_ctrl: sequencer of the row sorter
// Handles host operations and steps the partition loop of the quicksort.
// ----------------------------------------------------------------------------
module rqs_ctrl import rqs_pkg::*; (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire logic [1:0]     op,
  input  wire logic [RW-1:0]  rows,
  input  wire logic [CCW-1:0] column_count,
  input  wire logic [KCW-1:0] key_column,
  output logic                out_valid,
  input  wire logic           out_stall,
  output logic                out_status,
  output logic                out_is_read,
  output logic                cap_read,
  output rqs_cmd_t            cmd,
  input  rqs_sts_t            sts
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_RANGE  = 4'd1;
  localparam logic [3:0] S_PVRD   = 4'd2;
  localparam logic [3:0] S_PVLD   = 4'd3;
  localparam logic [3:0] S_IRD    = 4'd4;
  localparam logic [3:0] S_ICHK   = 4'd5;
  localparam logic [3:0] S_JRD    = 4'd6;
  localparam logic [3:0] S_JCHK   = 4'd7;
  localparam logic [3:0] S_RDROW  = 4'd8;
  localparam logic [3:0] S_RDLAST = 4'd9;
  localparam logic [3:0] S_WRROW  = 4'd10;
  localparam logic [3:0] S_DONE   = 4'd11;
  localparam logic [3:0] S_RDCAP  = 4'd12;

  logic [3:0] state, state_next;
  logic       accept, geo_ok;
  logic       rd_phase;          // during row read: 0 reads row i, 1 row j
  logic       wr_phase;
  logic [17:0] prod;

  assign prod   = 18'(rows) * 18'(column_count);
  assign geo_ok = column_count != '0 && column_count <= CCW'(MAX_COLUMNS) &&
                  {1'b0, key_column} < column_count && prod <= 18'(STORE_WORDS);
  // result register must be free before a new item is taken
  assign in_stall = state != S_IDLE || (out_valid && out_stall);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    cmd = '0;
    state_next = state;
    cap_read = 1'b0;
    case (state)
      S_IDLE: begin
        cmd.mem_addr_sel = MA_HOST;
        cmd.mem_wdata_host = 1'b1;
        if (accept) begin
          if (op == OP_WRITE) cmd.mem_we = 1'b1;
          if (op == OP_READ) state_next = S_RDCAP;
          if (op == OP_SORT && geo_ok) begin
            cmd.start_sort = 1'b1;
            state_next = S_RANGE;
          end
        end
      end
      S_RDCAP: begin
        cap_read = 1'b1;
        state_next = S_IDLE;
      end
      S_RANGE: begin
        if (sts.n_gt1) begin
          cmd.load_range = 1'b1;
          state_next = S_PVRD;
        end else if (sts.stack_empty) begin
          state_next = S_DONE;
        end else begin
          cmd.pop = 1'b1;
        end
      end
      S_PVRD: begin
        cmd.mem_addr_sel = MA_PIVOT;
        state_next = S_PVLD;
      end
      S_PVLD: begin
        cmd.load_pivot = 1'b1;
        state_next = S_IRD;
      end
      S_IRD: begin
        if (sts.i_le_j) begin
          cmd.mem_addr_sel = MA_KEYI;
          state_next = S_ICHK;
        end else begin
          cmd.finish_part = 1'b1;
          state_next = S_RANGE;
        end
      end
      S_ICHK: begin
        if (sts.key_lt) begin
          cmd.inc_i = 1'b1;
          state_next = S_IRD;
        end else begin
          state_next = S_JRD;
        end
      end
      S_JRD: begin
        if (sts.i_le_j) begin
          cmd.mem_addr_sel = MA_KEYJ;
          state_next = S_JCHK;
        end else begin
          cmd.finish_part = 1'b1;
          state_next = S_RANGE;
        end
      end
      S_JCHK: begin
        if (sts.key_gt) begin
          cmd.dec_j = 1'b1;
          state_next = S_JRD;
        end else begin
          cmd.col_clr = 1'b1;
          state_next = S_RDROW;
        end
      end
      // reads alternate i and j words; the registered data is taken into the buffers in S_RDLAST
      S_RDROW: begin
        cmd.mem_addr_sel = rd_phase ? MA_ROWJ : MA_ROWI;
        state_next = S_RDLAST;
      end
      S_RDLAST: begin
        cmd.buf_i_we = !rd_phase;
        cmd.buf_j_we = rd_phase;
        if (rd_phase && sts.col_last) begin
          cmd.col_clr = 1'b1;
          state_next = S_WRROW;
        end else begin
          cmd.col_inc = rd_phase;
          state_next = S_RDROW;
        end
      end
      S_WRROW: begin
        cmd.mem_we = 1'b1;
        cmd.mem_addr_sel = wr_phase ? MA_ROWI : MA_ROWJ;
        cmd.wr_to_j = !wr_phase;
        if (wr_phase) begin
          if (sts.col_last) begin
            cmd.inc_i = 1'b1;
            cmd.dec_j = 1'b1;
            state_next = S_IRD;
          end else begin
            cmd.col_inc = 1'b1;
          end
        end
      end
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      rd_phase <= 1'b0;
      wr_phase <= 1'b0;
      out_valid <= 1'b0;
      out_status <= 1'b0;
      out_is_read <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_RDLAST) rd_phase <= !rd_phase;
      if (state == S_WRROW) wr_phase <= !wr_phase;
      if (accept) begin
        out_is_read <= (op == OP_READ);
        out_status  <= (op == OP_UNUSED) || (op == OP_SORT && !geo_ok);
      end
      // writes, rejected sorts and unused codes answer right away
      if (accept && op != OP_READ && !(op == OP_SORT && geo_ok)) begin
        out_valid <= 1'b1;
      end else if (state == S_RDCAP || state == S_DONE) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ----- hdl/row_quicksort_by_key_column.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// row_quicksort_by_key_column: row table store with in-place quicksort
// Top level joining the sequencer and the datapath.
// ----------------------------------------------------------------------------
// usage
//   input channel: operation, word_index, write_value, row_count with
//   in_valid / in_stall; one result (read_data, status) per item on
//   out_valid / out_stall, held in a result register until taken.
//   write: result in the cycle after accept, one item per cycle while the
//   receiver does not stall. read: registered store read; the next item
//   waits until it is done. sort: data dependent, bounded by the partition
//   walk over one store port: range setup (S_RANGE, S_PVRD, S_PVLD), key
//   compares (read, check), row swaps; expected O(n log n) such steps.
//   a new item is taken only once the previous one is finished and its
//   result register is free, so a stalled receiver holds off the input.
//   configuration: cfg_we, cfg_index, cfg_data; write only while idle.
//   reset sets column_count 1, key_column 0; store contents undefined until
//   written.
// ----------------------------------------------------------------------------
module row_quicksort_by_key_column import rqs_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         operation,
  input  wire logic [11:0]        word_index,
  input  wire logic signed [31:0] write_value,
  input  wire logic [12:0]        row_count,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      read_data,
  output logic                    status,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [31:0]        cfg_data
);

  rqs_cmd_t           cmd;
  rqs_sts_t           sts;
  logic [CCW-1:0]     column_count;
  logic [KCW-1:0]     key_column;
  logic               is_read, cap_read;
  logic signed [31:0] rd_word, rd_hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= CCW'(1);
      key_column <= '0;
    end else if (cfg_we) begin
      if (cfg_index == REG_COLUMN_COUNT) column_count <= cfg_data[CCW-1:0];
      if (cfg_index == REG_KEY_COLUMN)   key_column <= cfg_data[KCW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cap_read) rd_hold <= rd_word;
  end

  assign read_data = is_read ? rd_hold : '0;

  rqs_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall,
    .op(operation), .rows(row_count), .column_count, .key_column,
    .out_valid, .out_stall, .out_status(status), .out_is_read(is_read),
    .cap_read, .cmd, .sts
  );

  rqs_datapath u_dp (
    .clk, .rst, .cmd, .sts,
    .host_addr(word_index), .host_data(write_value),
    .column_count, .key_column, .rows(row_count), .rd_word
  );

endmodule
`default_nettype wire

// ----- hdl/rqs_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rqs_checker: port level checks of the row sorter
// Handshake and result checks bound to the top level.
// ----------------------------------------------------------------------------
module rqs_checker import rqs_pkg::*; (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic [1:0]  operation,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [31:0] read_data,
  input wire logic        status
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(read_data) && $stable(status))
    else $error("result changed while stalled");

  a_bad_op: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && operation == OP_UNUSED |=> out_valid && status)
    else $error("unused operation not flagged");

  a_write_ok: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && operation == OP_WRITE |=> out_valid && read_data == '0)
    else $error("write result wrong");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> in_stall)
    else $error("input taken with result pending");

endmodule

bind row_quicksort_by_key_column rqs_checker u_chk (
  .clk, .rst, .in_valid, .in_stall, .operation, .out_valid, .out_stall,
  .read_data, .status
);
`default_nettype wire

// ----- tb/row_quicksort_by_key_column_tb.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// row_quicksort_by_key_column_tb: self-checking bench of the row sorter
// Loads row tables with word writes, sorts them by the key column under
// several geometries, and reads words back. A model of the table store and
// the quicksort, kept in the bench, predicts each result. Random gaps and
// stalls are applied on both channels.
// ----------------------------------------------------------------------------
module row_quicksort_by_key_column_tb;
  import rqs_pkg::*;

  typedef struct packed {
    logic signed [31:0] data;
    logic               st;
  } sort_result_t;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         operation;
  logic [11:0]        word_index;
  logic signed [31:0] write_value;
  logic [12:0]        row_count;
  logic               out_valid;
  logic               out_stall;
  logic signed [31:0] read_data;
  logic               status;
  logic               cfg_we;
  logic [1:0]         cfg_index;
  logic [31:0]        cfg_data;

  localparam int TABLE_STACK = 40;

  row_quicksort_by_key_column dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .operation(operation), .word_index(word_index),
    .write_value(write_value), .row_count(row_count),
    .out_valid(out_valid), .out_stall(out_stall),
    .read_data(read_data), .status(status),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // table model
  int           table_words[STORE_WORDS];
  bit           word_written[STORE_WORDS];
  int           written_list[$];
  int unsigned  cols;
  int unsigned  keycol;
  sort_result_t pending_results[$];

  int  items_sent;
  int  results_seen;
  int  mismatches;
  int  sorts_done;
  bit  quiet_mode;
  bit  hold_req;
  int  hold_len;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #(20 * 3000000);
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("Verification failed");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet_mode || r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int row_key(int unsigned row);
    int unsigned a;
    a = row * cols + keycol;
    return (a < STORE_WORDS) ? table_words[a] : 0;
  endfunction

  function automatic void swap_table_rows(int unsigned a, int unsigned b);
    int tmp;
    for (int unsigned c = 0; c < cols && c < MAX_COLUMNS; c++) begin
      tmp = table_words[a * cols + c];
      table_words[a * cols + c] = table_words[b * cols + c];
      table_words[b * cols + c] = tmp;
    end
  endfunction

  function automatic void quicksort_rows(int unsigned total);
    int unsigned base, n, lcount, rstart, rcount;
    int i, j, pivot;
    int unsigned range_base[$];
    int unsigned range_len[$];
    base = 0;
    n = total;
    forever begin
      while (n > 1) begin
        i = 0;
        j = n - 1;
        pivot = row_key(base + n / 2);
        while (i <= j) begin
          while (i <= j && row_key(base + i) < pivot) i++;
          while (i <= j && row_key(base + j) > pivot) j--;
          if (i <= j) begin
            swap_table_rows(base + i, base + j);
            i++;
            j--;
          end
        end
        lcount = j + 1;
        rstart = base + i;
        rcount = n - i;
        // the larger side waits on the stack
        if (lcount < rcount) begin
          if (rcount > 1 && range_base.size() < TABLE_STACK) begin
            range_base.push_back(rstart);
            range_len.push_back(rcount);
          end
          n = lcount;
        end else begin
          if (lcount > 1 && range_base.size() < TABLE_STACK) begin
            range_base.push_back(base);
            range_len.push_back(lcount);
          end
          base = rstart;
          n = rcount;
        end
      end
      if (range_base.size() == 0) break;
      base = range_base.pop_back();
      n = range_len.pop_back();
    end
  endfunction

  function automatic bit sort_is_legal(int unsigned rows);
    return !(cols == 0 || cols > MAX_COLUMNS || keycol >= cols ||
             rows * cols > STORE_WORDS);
  endfunction

  function automatic bit prefix_written(int unsigned words);
    for (int unsigned k = 0; k < words; k++)
      if (!word_written[k]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic sort_result_t predict_item(logic [1:0] op, logic [11:0] idx,
                                                logic [31:0] val, logic [12:0] rows);
    sort_result_t r;
    r = '0;
    case (op)
      OP_WRITE: begin
        table_words[idx] = val;
        if (!word_written[idx]) written_list.push_back(idx);
        word_written[idx] = 1'b1;
      end
      OP_SORT: begin
        if (!sort_is_legal(rows)) r.st = 1'b1;
        else quicksort_rows(rows);
      end
      OP_READ: r.data = table_words[idx];
      default: r.st = 1'b1;
    endcase
    return r;
  endfunction

  task automatic send_item(logic [1:0] op, logic [11:0] idx, logic [31:0] val,
                           logic [12:0] rows);
    int g;
    g = pick_gap();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    operation   <= op;
    word_index  <= idx;
    write_value <= val;
    row_count   <= rows;
    in_valid    <= 1'b1;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(predict_item(op, idx, val, rows));
    items_sent++;
    if (op == OP_SORT) sorts_done++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_config(logic [1:0] idx, int unsigned value);
    drain();
    cfg_index <= idx;
    cfg_data  <= value;
    cfg_we    <= 1'b1;
    @(negedge clk);
    cfg_we    <= 1'b0;
    if (idx == REG_COLUMN_COUNT) cols = value & 32'h1f;
    else if (idx == REG_KEY_COLUMN) keycol = value & 32'hf;
  endtask

  task automatic set_geometry(int unsigned c, int unsigned k);
    write_config(REG_COLUMN_COUNT, c);
    write_config(REG_KEY_COLUMN, k);
  endtask

  task automatic read_random_word();
    if (written_list.size() == 0) return;
    send_item(OP_READ, written_list[$urandom_range(0, written_list.size() - 1)],
              $urandom, $urandom);
  endtask

  // loads nrows rows, sorts them or a leading part of them and reads back some words of the table
  task automatic load_and_sort(int unsigned nrows, bit ties, bit sort_fewer);
    int unsigned words, sr;
    logic [31:0] v;
    words = nrows * cols;
    for (int unsigned k = 0; k < words; k++) begin
      v = ties ? $urandom_range(0, 3) - 1 : $urandom;
      send_item(OP_WRITE, k, v, $urandom);
    end
    sr = sort_fewer ? $urandom_range(0, nrows) : nrows;
    send_item(OP_SORT, $urandom, $urandom, sr);
    for (int k = 0; k < 4; k++)
      send_item(OP_READ, $urandom_range(0, words - 1), $urandom, $urandom);
  endtask

  // result checking
  always @(posedge clk) begin
    sort_result_t e;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result with nothing expected: data %0d status %0d",
                                       read_data, status);
      end else begin
        e = pending_results.pop_front();
        if (read_data !== e.data || status !== e.st) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch at result %0d: expected data %0d status %0d, got %0d %0d",
                     results_seen, e.data, e.st, read_data, status);
        end
      end
    end
  end

  // receiver stalls, with a long hold-off on request
  initial begin
    int stall_left;
    stall_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (hold_len) @(negedge clk);
        hold_req = 1'b0;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        if (!quiet_mode && $urandom_range(0, 99) < 20) stall_left = pick_gap();
      end
    end
  end

  task automatic test_directed();
    set_geometry(1, 0);
    send_item(OP_WRITE, 0, 32'h7fffffff, 0);
    send_item(OP_WRITE, 1, 32'h80000000, 0);
    send_item(OP_WRITE, 4095, 32'hffffffff, 13'h1fff);
    send_item(OP_READ, 0, 0, 0);
    send_item(OP_READ, 1, 0, 0);
    send_item(OP_READ, 4095, 0, 0);
    send_item(OP_UNUSED, 12'hfff, 32'hffffffff, 13'h1fff);
    send_item(OP_SORT, 0, 0, 0);      // empty sort
    send_item(OP_SORT, 0, 0, 1);      // one row
    send_item(OP_SORT, 0, 0, 2);      // max against min key
    send_item(OP_READ, 0, 0, 0);
    send_item(OP_SORT, 0, 0, 13'h1fff); // too many rows
    set_geometry(2, 3);
    send_item(OP_SORT, 0, 0, 1);      // key column past the row
    set_geometry(0, 0);
    send_item(OP_SORT, 0, 0, 0);      // no columns
    set_geometry(31, 0);
    send_item(OP_SORT, 0, 0, 1);      // too many columns
    set_geometry(16, 15);
    send_item(OP_SORT, 0, 0, 257);    // one row past the store
    send_item(OP_SORT, 0, 0, 256 * 0 + 1);
  endtask

  task automatic test_large_tables();
    quiet_mode = 1'b1;
    set_geometry(1, 0);
    load_and_sort(256, 0, 0);
    set_geometry(16, 7);
    load_and_sort(12, 1, 0);
    quiet_mode = 1'b0;
  endtask

  task automatic test_backpressure();
    set_geometry(4, 2);
    hold_len = 300;
    hold_req = 1'b1;
    load_and_sort(6, 0, 0);
    for (int k = 0; k < 20; k++) read_random_word();
    // sender pauses until everything is back
    drain();
    load_and_sort(5, 1, 0);
  endtask

  task automatic test_random();
    int start, r;
    int unsigned c, k, nr, cap;
    start = items_sent;
    while (items_sent - start < 600) begin
      r = $urandom_range(0, 9);
      c = (r == 0) ? 1 : (r == 1) ? 16 : $urandom_range(1, 16);
      k = (r == 1) ? 15 : $urandom_range(0, c - 1);
      if ($urandom_range(0, 9) == 0) k = $urandom_range(c, 15 + (c == 16));
      set_geometry(c, k & 15);
      quiet_mode = ($urandom_range(0, 4) == 0);
      for (int s = 0; s < 8; s++) begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          cap = STORE_WORDS / cols;
          if (cap > 64) cap = 64;
          nr = ($urandom_range(0, 9) == 0) ? $urandom_range(2, cap)
                                            : $urandom_range(2, cap < 12 ? cap : 12);
          load_and_sort(nr, $urandom_range(0, 1), $urandom_range(0, 4) == 0);
        end else if (r < 75) begin
          repeat (4) read_random_word();
        end else if (r < 90) begin
          repeat (4) send_item(OP_WRITE, $urandom, $urandom, $urandom);
        end else begin
          send_item(OP_UNUSED, $urandom, $urandom, $urandom);
          nr = $urandom_range(0, 8191);
          // a legal sort must only touch words already loaded
          if (sort_is_legal(nr) && nr > 1 && !prefix_written(nr * cols)) nr = 8191;
          send_item(OP_SORT, $urandom, $urandom, nr);
        end
      end
      quiet_mode = 1'b0;
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    operation = OP_WRITE;
    word_index = '0;
    write_value = '0;
    row_count = '0;
    cfg_we = 1'b0;
    cfg_index = REG_COLUMN_COUNT;
    cfg_data = '0;
    cols = 1;
    keycol = 0;
    items_sent = 0;
    results_seen = 0;
    mismatches = 0;
    sorts_done = 0;
    quiet_mode = 1'b0;
    hold_req = 1'b0;
    hold_len = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_large_tables();
    test_backpressure();
    test_random();
    drain();
    repeat (20) @(negedge clk);
    $display("%0d items sent, %0d results checked, %0d sorts over varied geometries",
             items_sent, results_seen, sorts_done);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, pending_results.size());
      $display("Verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
